// ----- rtl/core/crlsd_pkg.sv -----
package crlsd_pkg;

    localparam int DEF_SCREEN_WIDTH  = 480;
    localparam int DEF_SCREEN_HEIGHT = 480;

    localparam int RUN_BITS   = 8;
    localparam int ROW_BITS   = 9;
    localparam int COLOR_BITS = 16;
    localparam int PIX_BITS   = 18;
    localparam int CFG_BITS   = 16;
    localparam int IDX_BITS   = 2;

    localparam int MIN_LOGO_WIDTH  = 16;
    localparam int MIN_LOGO_HEIGHT = 1;

    localparam logic [RUN_BITS-1:0]   RUN_KEEP_COLOR = 8'hFF;
    localparam logic [COLOR_BITS-1:0] BG_COLOR       = 16'h0000;

    localparam logic [IDX_BITS-1:0] REG_LOGO_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_LOGO_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_FG_COLOR    = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_FIRST_FG    = 2'd3;

    localparam logic [ROW_BITS-1:0]   RST_LOGO_WIDTH  = 9'd128;
    localparam logic [ROW_BITS-1:0]   RST_LOGO_HEIGHT = 9'd128;
    localparam logic [COLOR_BITS-1:0] RST_FG_COLOR    = 16'hFFFF;
    localparam logic                  RST_FIRST_FG    = 1'b0;

    typedef struct packed {
        logic [RUN_BITS-1:0] run_length;
        logic                last_run;
    } run_item_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] span_color;
        logic [PIX_BITS-1:0]   span_pixels;
        logic                  last_span;
        logic                  frame_end;
        logic                  table_short;
    } span_item_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LOGO  = 2'd1,
        PH_DRAIN = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEOM,
        S_TOP,
        S_LEFT0,
        S_LOOP,
        S_ROWEND,
        S_TAIL,
        S_FILL,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_TOP,
        SRC_X,
        SRC_RIGHT,
        SRC_BOTTOM,
        SRC_CHUNK,
        SRC_FILL
    } span_src_t;

    typedef struct packed {
        logic      load_item;
        logic      load_geom;
        logic      init_frame;
        span_src_t src;
        logic      emit;
        logic      set_fe;
        logic      set_short;
        logic      chunk_step;
        logic      row_step;
        logic      toggle;
        logic      fill_prep;
        logic      flush;
    } dp_cmd_t;

    typedef struct packed {
        logic rpl_zero;
        logic left_zero;
        logic last_row;
        logic item_last;
        logic pend_valid;
        logic out_free;
        logic can_emit;
    } dp_status_t;

endpackage

// ----- rtl/core/crlsd_ctrl.sv -----
module crlsd_ctrl import crlsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.src    = SRC_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_GEOM;
                end
            end
            S_GEOM: begin
                cmd.load_geom = 1'b1;
                if (phase_reg == PH_DRAIN) begin
                    if (sts.item_last) begin
                        phase_next = PH_IDLE;
                    end
                    state_next = S_IDLE;
                end else if (phase_reg == PH_LOGO) begin
                    state_next = S_LOOP;
                end else begin
                    cmd.init_frame = 1'b1;
                    phase_next     = PH_LOGO;
                    state_next     = S_TOP;
                end
            end
            S_TOP: begin
                if (sts.can_emit) begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_TOP;
                    state_next = S_LEFT0;
                end
            end
            S_LEFT0: begin
                if (sts.can_emit) begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_X;
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (sts.rpl_zero) begin
                    if (sts.can_emit) begin
                        cmd.emit   = 1'b1;
                        cmd.src    = SRC_RIGHT;
                        state_next = S_ROWEND;
                    end
                end else if (sts.left_zero) begin
                    state_next = S_TAIL;
                end else if (sts.can_emit) begin
                    cmd.emit       = 1'b1;
                    cmd.src        = SRC_CHUNK;
                    cmd.chunk_step = 1'b1;
                end
            end
            S_ROWEND: begin
                if (sts.can_emit) begin
                    cmd.emit = 1'b1;
                    if (sts.last_row) begin
                        cmd.src    = SRC_BOTTOM;
                        cmd.set_fe = 1'b1;
                        phase_next = sts.item_last ? PH_IDLE : PH_DRAIN;
                        state_next = S_FINISH;
                    end else begin
                        cmd.src      = SRC_X;
                        cmd.row_step = 1'b1;
                        state_next   = S_LOOP;
                    end
                end
            end
            S_TAIL: begin
                cmd.toggle = 1'b1;
                if (sts.item_last) begin
                    cmd.fill_prep = 1'b1;
                    state_next    = S_FILL;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FILL: begin
                if (sts.can_emit) begin
                    cmd.emit      = 1'b1;
                    cmd.src       = SRC_FILL;
                    cmd.set_fe    = 1'b1;
                    cmd.set_short = 1'b1;
                    phase_next    = PH_IDLE;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!sts.pend_valid) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/crlsd_dp.sv -----
module crlsd_dp import crlsd_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  run_item_t           s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output span_item_t          m_data,
    input  dp_cmd_t             cmd,
    output dp_status_t          sts
);

    localparam int XW   = $clog2(SCREEN_WIDTH + 1);
    localparam int YW   = $clog2(SCREEN_HEIGHT + 1);
    localparam int GW0  = (XW > YW) ? XW : YW;
    localparam int GW   = (GW0 > ROW_BITS) ? GW0 : ROW_BITS;
    localparam int PW   = XW + YW;
    localparam int SUMW = (PW + 1 > PIX_BITS) ? PW + 1 : PIX_BITS;

    localparam logic [GW-1:0] SW_G    = GW'(SCREEN_WIDTH);
    localparam logic [GW-1:0] SH_G    = GW'(SCREEN_HEIGHT);
    localparam logic [GW-1:0] MIN_W_G = GW'(MIN_LOGO_WIDTH);
    localparam logic [GW-1:0] MIN_H_G = GW'(MIN_LOGO_HEIGHT);
    localparam logic [PW-1:0] SW_P    = PW'(SCREEN_WIDTH);

    logic [ROW_BITS-1:0]   logo_width_reg;
    logic [ROW_BITS-1:0]   logo_height_reg;
    logic [COLOR_BITS-1:0] fg_color_reg;
    logic                  first_fg_reg;

    logic [RUN_BITS-1:0] run_reg;
    logic                last_reg;
    logic [RUN_BITS-1:0] left_px_reg;

    logic [GW-1:0] lw_reg, lh_reg, x_reg, y_reg, right_reg, botrows_reg;
    logic [PW-1:0] fill_prod_reg;

    logic [ROW_BITS-1:0] logo_row_reg;
    logic [ROW_BITS-1:0] rpl_reg;
    logic                df_reg;

    span_item_t pend_reg;
    logic       pend_valid_reg;
    span_item_t m_data_reg;
    logic       m_valid_reg;

    logic [GW-1:0]       lw_cfg, lh_cfg, eff_w, eff_h, x_next, y_next;
    logic [PW-1:0]       top_prod, bottom_prod;
    logic                last_row;
    logic [GW-1:0]       rows_after;
    logic [GW-1:0]       rows_sum;
    logic [ROW_BITS-1:0] chunk;
    logic [SUMW-1:0]     span_val;
    logic                span_nz;
    logic                do_emit;
    logic                fe_only;
    logic                out_free;
    logic                out_push;
    span_item_t          new_span;
    span_item_t          push_span;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logo_width_reg  <= RST_LOGO_WIDTH;
            logo_height_reg <= RST_LOGO_HEIGHT;
            fg_color_reg    <= RST_FG_COLOR;
            first_fg_reg    <= RST_FIRST_FG;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LOGO_WIDTH:  logo_width_reg  <= cfg_wdata[ROW_BITS-1:0];
                REG_LOGO_HEIGHT: logo_height_reg <= cfg_wdata[ROW_BITS-1:0];
                REG_FG_COLOR:    fg_color_reg    <= cfg_wdata[COLOR_BITS-1:0];
                REG_FIRST_FG:    first_fg_reg    <= cfg_wdata[0];
            endcase
        end
    end

    // saturated geometry from the configuration
    always_comb begin
        lw_cfg = GW'(logo_width_reg);
        lh_cfg = GW'(logo_height_reg);
        if (lw_cfg < MIN_W_G) begin
            eff_w = MIN_W_G;
        end else if (lw_cfg > SW_G) begin
            eff_w = SW_G;
        end else begin
            eff_w = lw_cfg;
        end
        if (lh_cfg < MIN_H_G) begin
            eff_h = MIN_H_G;
        end else if (lh_cfg > SH_G) begin
            eff_h = SH_G;
        end else begin
            eff_h = lh_cfg;
        end
        x_next = (SW_G - eff_w) >> 1;
        y_next = (SH_G - eff_h) >> 1;
    end

    assign top_prod    = PW'(y_reg) * SW_P;
    assign bottom_prod = PW'(botrows_reg) * SW_P;
    assign last_row    = ((GW + 1)'(logo_row_reg) + (GW + 1)'(1)) >= (GW + 1)'(lh_reg);
    assign rows_after  = last_row ? '0 : (lh_reg - GW'(1) - GW'(logo_row_reg));
    assign rows_sum    = rows_after + botrows_reg;
    assign chunk       = (ROW_BITS'(left_px_reg) < rpl_reg) ? ROW_BITS'(left_px_reg) : rpl_reg;

    always_comb begin
        case (cmd.src)
            SRC_TOP:    span_val = SUMW'(top_prod);
            SRC_X:      span_val = SUMW'(x_reg);
            SRC_RIGHT:  span_val = SUMW'(right_reg);
            SRC_BOTTOM: span_val = SUMW'(bottom_prod);
            SRC_CHUNK:  span_val = SUMW'(chunk);
            SRC_FILL:   span_val = SUMW'(fill_prod_reg) + SUMW'(rpl_reg) + SUMW'(right_reg);
            default:    span_val = '0;
        endcase
        new_span.span_color  = (cmd.src == SRC_CHUNK && df_reg) ? fg_color_reg : BG_COLOR;
        new_span.span_pixels = span_val[PIX_BITS-1:0];
        new_span.last_span   = 1'b0;
        new_span.frame_end   = cmd.set_fe;
        new_span.table_short = cmd.set_short;
    end

    always_comb begin
        push_span           = pend_reg;
        push_span.last_span = cmd.flush;
    end

    assign span_nz  = (span_val != '0);
    assign do_emit  = cmd.emit && span_nz;
    assign fe_only  = cmd.emit && !span_nz && cmd.set_fe;
    assign out_free = !m_valid_reg || m_ready;
    assign out_push = (do_emit && pend_valid_reg) || cmd.flush;

    // item and frame registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            run_reg     <= s_data.run_length;
            last_reg    <= s_data.last_run;
            left_px_reg <= s_data.run_length;
        end else if (cmd.chunk_step) begin
            left_px_reg <= left_px_reg - RUN_BITS'(chunk);
        end
        if (cmd.load_geom) begin
            lw_reg      <= eff_w;
            lh_reg      <= eff_h;
            x_reg       <= x_next;
            y_reg       <= y_next;
            right_reg   <= SW_G - x_next - eff_w;
            botrows_reg <= SH_G - y_next - eff_h;
        end
        if (cmd.fill_prep) begin
            fill_prod_reg <= PW'(rows_sum) * SW_P;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logo_row_reg <= '0;
            rpl_reg      <= '0;
            df_reg       <= 1'b0;
        end else begin
            if (cmd.init_frame) begin
                logo_row_reg <= '0;
                rpl_reg      <= ROW_BITS'(eff_w);
                df_reg       <= first_fg_reg;
            end else if (cmd.row_step) begin
                logo_row_reg <= logo_row_reg + ROW_BITS'(1);
                rpl_reg      <= ROW_BITS'(lw_reg);
            end else if (cmd.chunk_step) begin
                rpl_reg <= rpl_reg - chunk;
            end
            if (cmd.toggle && run_reg != RUN_KEEP_COLOR) begin
                df_reg <= !df_reg;
            end
        end
    end

    // one span held back so the last one of a transaction can be flagged
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (do_emit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            pend_reg <= new_span;
        end else if (fe_only) begin
            pend_reg.frame_end <= 1'b1;
        end
        if (out_push) begin
            m_data_reg <= push_span;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sts.rpl_zero   = (rpl_reg == '0);
        sts.left_zero  = (left_px_reg == '0);
        sts.last_row   = last_row;
        sts.item_last  = last_reg;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
        sts.can_emit   = !pend_valid_reg || out_free;
    end

endmodule

// ----- rtl/core/centered_rle_logo_span_decoder.sv -----
// channel   direction  handshake          payload
// config    in         cfg_we             cfg_index, cfg_wdata
// runs      in         s_valid / s_ready  s_data (run_length, last_run)
// spans     out        m_valid / m_ready  m_data (color, pixels, flags)
//
// a run byte is walked through its span slots in turn (chunks, margins, borders, fill;
// a zero-length slot still takes its sequencer step but emits no span); a run that
// completes the frame ends there, and runs after the frame are dropped without spans
// s_ready is high only between transactions; a stalled m_ready holds the sequencer
// reset is synchronous on aresetn low and restores the default geometry and colors
module centered_rle_logo_span_decoder import crlsd_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  run_item_t           s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output span_item_t          m_data
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    crlsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    crlsd_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- test/centered_rle_logo_span_decoder_check.sv -----
`timescale 1ns / 100ps

module centered_rle_logo_span_decoder_check import crlsd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  run_item_t           s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  span_item_t          m_data,
    output int                  error_count,
    output int                  spans_owed
);

    localparam int unsigned SCREEN_W = DEF_SCREEN_WIDTH;
    localparam int unsigned SCREEN_H = DEF_SCREEN_HEIGHT;

    logic [ROW_BITS-1:0]   width_reg;
    logic [ROW_BITS-1:0]   height_reg;
    logic [COLOR_BITS-1:0] fg_reg;
    logic                  first_fg_reg;

    phase_t              phase;
    logic [ROW_BITS-1:0] logo_row;
    logic [ROW_BITS-1:0] row_pix_left;
    logic                draw_fg;

    span_item_t pending_spans[$];
    span_item_t batch[$];
    int         errors = 0;

    function automatic void add_span(input logic [COLOR_BITS-1:0] color,
                                     input int unsigned pix, input logic short_fill);
        span_item_t s;
        if (pix == 0) return;
        s.span_color  = color;
        s.span_pixels = pix[PIX_BITS-1:0];
        s.last_span   = 1'b0;
        s.frame_end   = 1'b0;
        s.table_short = short_fill;
        batch.push_back(s);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want !== got) begin
            errors++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic predict_spans(input run_item_t item);
        int unsigned lw, lh, x0, y0, right, bottom, left_px, chunk, rows_after;
        bit done;
        bit walking;
        lw = 32'(width_reg);
        if (lw < MIN_LOGO_WIDTH) lw = MIN_LOGO_WIDTH;
        if (lw > SCREEN_W) lw = SCREEN_W;
        lh = 32'(height_reg);
        if (lh < MIN_LOGO_HEIGHT) lh = MIN_LOGO_HEIGHT;
        if (lh > SCREEN_H) lh = SCREEN_H;
        x0      = (SCREEN_W - lw) / 2;
        y0      = (SCREEN_H - lh) / 2;
        right   = SCREEN_W - x0 - lw;
        bottom  = (SCREEN_H - y0 - lh) * SCREEN_W;
        left_px = 32'(item.run_length);
        done    = 1'b0;
        walking = 1'b1;
        batch.delete();

        if (phase == PH_DRAIN) begin
            if (item.last_run) phase = PH_IDLE;
            return;
        end
        if (phase != PH_LOGO) begin
            logo_row     = '0;
            row_pix_left = lw[ROW_BITS-1:0];
            draw_fg      = first_fg_reg;
            phase        = PH_LOGO;
            add_span(BG_COLOR, y0 * SCREEN_W, 1'b0);
            add_span(BG_COLOR, x0, 1'b0);
        end

        while (walking) begin
            if (row_pix_left == 0) begin
                add_span(BG_COLOR, right, 1'b0);
                if (32'(logo_row) + 1 >= lh) begin
                    add_span(BG_COLOR, bottom, 1'b0);
                    if (batch.size() > 0) batch[batch.size() - 1].frame_end = 1'b1;
                    done    = 1'b1;
                    walking = 1'b0;
                    phase   = item.last_run ? PH_IDLE : PH_DRAIN;
                end else begin
                    logo_row     = logo_row + 1'b1;
                    row_pix_left = lw[ROW_BITS-1:0];
                    add_span(BG_COLOR, x0, 1'b0);
                end
            end else if (left_px == 0) begin
                walking = 1'b0;
            end else begin
                chunk = (left_px < 32'(row_pix_left)) ? left_px : 32'(row_pix_left);
                add_span(draw_fg ? fg_reg : BG_COLOR, chunk, 1'b0);
                left_px      = left_px - chunk;
                row_pix_left = row_pix_left - chunk[ROW_BITS-1:0];
            end
        end

        if (!done) begin
            if (item.run_length != RUN_KEEP_COLOR) draw_fg = ~draw_fg;
            if (item.last_run) begin
                rows_after = (32'(logo_row) + 1 >= lh) ? 0 : lh - 1 - 32'(logo_row);
                add_span(BG_COLOR, 32'(row_pix_left) + right + rows_after * SCREEN_W + bottom,
                         1'b1);
                if (batch.size() > 0) batch[batch.size() - 1].frame_end = 1'b1;
                phase = PH_IDLE;
            end
        end

        if (batch.size() > 0) batch[batch.size() - 1].last_span = 1'b1;
        foreach (batch[i]) pending_spans.push_back(batch[i]);
    endtask

    always @(posedge aclk) begin
        span_item_t want;
        if (!aresetn) begin
            width_reg    = RST_LOGO_WIDTH;
            height_reg   = RST_LOGO_HEIGHT;
            fg_reg       = RST_FG_COLOR;
            first_fg_reg = RST_FIRST_FG;
            phase        = PH_IDLE;
            logo_row     = '0;
            row_pix_left = '0;
            draw_fg      = 1'b0;
            pending_spans.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_spans.size() == 0) begin
                    errors++;
                    $display("%0t unexpected span: color %h pixels %0d", $time,
                             m_data.span_color, m_data.span_pixels);
                end else begin
                    want = pending_spans.pop_front();
                    check_field("span_color", 32'(want.span_color), 32'(m_data.span_color));
                    check_field("span_pixels", 32'(want.span_pixels),
                                32'(m_data.span_pixels));
                    check_field("last_span", 32'(want.last_span), 32'(m_data.last_span));
                    check_field("frame_end", 32'(want.frame_end), 32'(m_data.frame_end));
                    check_field("table_short", 32'(want.table_short),
                                32'(m_data.table_short));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_LOGO_WIDTH: width_reg = cfg_wdata[ROW_BITS-1:0];
                    REG_LOGO_HEIGHT: height_reg = cfg_wdata[ROW_BITS-1:0];
                    REG_FG_COLOR: fg_reg = cfg_wdata[COLOR_BITS-1:0];
                    REG_FIRST_FG: first_fg_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_spans(s_data);
        end
        error_count <= errors;
        spans_owed  <= pending_spans.size();
    end

endmodule

// ----- test/centered_rle_logo_span_decoder_test.sv -----
`timescale 1ns / 100ps

module centered_rle_logo_span_decoder_test;
    import crlsd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 12;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_BITS-1:0] cfg_index = REG_LOGO_WIDTH;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    run_item_t           s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    span_item_t          m_data;

    int   mismatch_total;
    int   spans_owed;
    int   cycle_count = 0;
    int   burst_left  = 0;
    logic hold_req    = 1'b0;

    centered_rle_logo_span_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    centered_rle_logo_span_decoder_check span_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (mismatch_total),
        .spans_owed  (spans_owed)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[centered_rle_logo_span_decoder] ERROR");
            $finish;
        end
    end

    // sender bursts: a random gap opens each new burst
    task automatic offer(input logic [RUN_BITS-1:0] run, input logic last);
        int  gap;
        logic ok;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= run_item_t'{run_length: run, last_run: last};
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (spans_owed != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                              input logic [CFG_BITS-1:0] fg, input logic [CFG_BITS-1:0] first);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOGO_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= REG_LOGO_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_index <= REG_FG_COLOR;
        cfg_wdata <= fg;
        @(posedge aclk);
        cfg_index <= REG_FIRST_FG;
        cfg_wdata <= first;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // receiver: stretches of always ready, coin flip or mostly stalled, and one long stall on request
    initial begin
        int mode;
        int stretch;
        int hold_left;
        bit held;
        mode      = 0;
        stretch   = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 2);
                    stretch = $urandom_range(10, 120);
                end
                stretch--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int                  ph;
        logic [RUN_BITS-1:0] len;
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] h;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // default geometry: empty first run, color hold, short table
        offer(8'd0, 1'b0);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(8'd1, 1'b0);
        offer(8'd200, 1'b0);
        offer(8'd0, 1'b1);
        wait_drained();

        // geometry below range, black foreground
        write_regs(16'd0, 16'd0, 16'h0000, 16'd1);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(8'd7, 1'b0);
        offer(8'd9, 1'b1);
        offer(8'd0, 1'b1);
        offer(8'd16, 1'b1);
        wait_drained();

        // geometry above range, full screen logo with no borders
        write_regs(16'hFFFF, 16'h01FF, 16'hFFFF, 16'hFFFE);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(8'd3, 1'b0);
        offer(8'd128, 1'b1);
        wait_drained();

        // odd margins, frame completes then runs are dropped
        write_regs(16'd479, 16'd2, 16'h5A5A, 16'd1);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(8'd200, 1'b0);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(RUN_KEEP_COLOR, 1'b0);
        offer(8'd10, 1'b0);
        offer(8'd5, 1'b1);
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            w = (ph == 2) ? 16'd480 : 16'($urandom_range(16, 64));
            h = (ph == 4) ? 16'd479 : 16'($urandom_range(1, 5));
            write_regs(w, h, 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 1)));
            if (ph == 0) hold_req <= 1'b1;
            repeat (21) begin
                case ($urandom_range(0, 9))
                    0: len = '0;
                    1, 2: len = RUN_KEEP_COLOR;
                    3, 4, 5: len = 8'($urandom_range(1, 24));
                    default: len = 8'($urandom_range(0, 255));
                endcase
                offer(len, $urandom_range(0, 9) == 0);
            end
            wait_drained();
        end

        if (mismatch_total == 0) begin
            $display("[centered_rle_logo_span_decoder] OK");
        end else begin
            $display("[centered_rle_logo_span_decoder] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/crlsd_pkg.sv
rtl/core/crlsd_ctrl.sv
rtl/core/crlsd_dp.sv
rtl/core/centered_rle_logo_span_decoder.sv
test/centered_rle_logo_span_decoder_check.sv
test/centered_rle_logo_span_decoder_test.sv
